FILE: rtl/dec_pkg.sv
// Shared types and constants for the depth edge classifier.
`default_nettype none
package dec_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WATER_LEVEL    = 2'd0;
    localparam logic [1:0] CFG_JUMP_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_RING_SCALE     = 2'd2;

    // Edge class codes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_MAJOR = 2'd1;
    localparam logic [1:0] CLS_MINOR = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_WATER_LEVEL    = 16'hFE0C;  // -500 m
    localparam logic [7:0]  RST_JUMP_TOLERANCE = 8'd13;
    localparam logic [15:0] RST_RING_SCALE     = 16'd40;

    typedef struct packed {
        logic [15:0] water_level;     // two's complement, metres
        logic [7:0]  jump_tolerance;  // 1/256 units
        logic [15:0] ring_scale;      // 1/16 m
    } t_cfg;

    typedef struct packed {
        logic [1:0] edge_class;
        logic       freeze;
    } t_cls_res;

endpackage
`default_nettype wire

FILE: rtl/depth_edge_classifier.sv
// Top level of the depth edge classifier: stream ports, pixel state and sequencing.
`default_nettype none
// Classifies a depth column walked bottom to top: each pixel transfer returns one edge
// class (0 none, 1 major, 2 minor contour) on the result stream, in order. Assert tuser
// on the first pixel of every column. A pixel takes restoring division by ring_scale
// (DIST_BITS-1 quotient bits) and a square root (ceil((DIST_BITS-1)/2) root bits), both
// on one shared subtractor, and then a handoff to the output register. A pixel in a frozen
// column (after sky) skips the division and the square root. The input is not ready while
// a pixel is in work; one finished result may wait in the output register meanwhile.
// Configuration writes are always ready and must only be issued while the block idles.
module depth_edge_classifier #(
    parameter int DIST_BITS = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [DIST_BITS-1:0] distance, [DIST_BITS+15:DIST_BITS] height, zero padded
    input  wire logic [((DIST_BITS+16+7)/8)*8-1:0] i_s_axis_tdata,
    // [0] column_start
    input  wire logic         i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [1:0] edge_class, zero padded
    output logic [7:0]        o_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);

    localparam int QW = DIST_BITS - 1;
    localparam int RW = (QW + 1) / 2;
    localparam int PW = DIST_BITS + 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]           r_state;
    dec_pkg::t_cfg        r_cfg;
    logic [DIST_BITS-1:0] r_d;
    logic [15:0]          r_h;
    logic                 r_start;
    logic                 r_skip;
    logic [DIST_BITS-1:0] r_absd;
    logic [DIST_BITS-1:0] r_absdiff;
    logic [PW-1:0]        r_rhs;
    logic [DIST_BITS-1:0] r_pd;
    logic [15:0]          r_ph;
    logic [RW-1:0]        r_pring;
    logic                 r_frozen;
    logic                 r_out_valid;
    logic [1:0]           r_out_class;

    logic                 accept;
    logic                 skip;
    logic [DIST_BITS-1:0] in_d;
    logic [15:0]          in_h;
    logic [DIST_BITS:0]   dd;
    logic [DIST_BITS:0]   neg_d;
    logic [QW-1:0]        dividend;
    logic                 root_done;
    logic [RW-1:0]        root;
    logic                 load_out;
    dec_pkg::t_cls_res    cls;

    assign in_d     = i_s_axis_tdata[DIST_BITS-1:0];
    assign in_h     = i_s_axis_tdata[DIST_BITS+15:DIST_BITS];
    assign accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign skip     = r_frozen & ~i_s_axis_tuser;
    assign dd       = {in_d[DIST_BITS-1], in_d} - {r_pd[DIST_BITS-1], r_pd};
    assign neg_d    = -{in_d[DIST_BITS-1], in_d};
    // sky has no ring: divide zero instead
    assign dividend = in_d[DIST_BITS-1] ? '0 : in_d[DIST_BITS-2:0];
    assign load_out = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);

    dec_root #(
        .QW(QW),
        .RW(RW)
    ) u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept & ~skip),
        .i_dividend (dividend),
        .i_divisor  (r_cfg.ring_scale),
        .o_done     (root_done),
        .o_root     (root)
    );

    dec_class #(
        .DIST_BITS(DIST_BITS),
        .RW       (RW)
    ) u_class (
        .i_d     (r_d),
        .i_h     (r_h),
        .i_pd    (r_pd),
        .i_ph    (r_ph),
        .i_ring  (root),
        .i_pring (r_pring),
        .i_lhs   ({r_absdiff, 8'd0}),
        .i_rhs   (r_rhs),
        .i_start (r_start),
        .i_cfg   (r_cfg),
        .o_res   (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pd        <= '0;
            r_ph        <= '0;
            r_pring     <= '0;
            r_frozen    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_d       <= in_d;
                        r_h       <= in_h;
                        r_start   <= i_s_axis_tuser;
                        r_skip    <= skip;
                        r_absd    <= in_d[DIST_BITS-1] ? neg_d[DIST_BITS-1:0] : in_d;
                        r_absdiff <= dd[DIST_BITS] ? DIST_BITS'(-dd) : dd[DIST_BITS-1:0];
                        r_state   <= skip ? ST_OUT : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rhs <= PW'(r_absd) * PW'(r_cfg.jump_tolerance);
                    if (root_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                        if (!r_skip) begin
                            r_pd    <= r_d;
                            r_ph    <= r_h;
                            r_pring <= root;
                            if (r_start) begin
                                r_frozen <= 1'b0;
                            end else if (cls.freeze) begin
                                r_frozen <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // hold the result until transfer
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_class <= r_skip ? dec_pkg::CLS_NONE : cls.edge_class;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.water_level    <= dec_pkg::RST_WATER_LEVEL;
            r_cfg.jump_tolerance <= dec_pkg::RST_JUMP_TOLERANCE;
            r_cfg.ring_scale     <= dec_pkg::RST_RING_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dec_pkg::CFG_WATER_LEVEL:    r_cfg.water_level    <= i_cfg_data;
                dec_pkg::CFG_JUMP_TOLERANCE: r_cfg.jump_tolerance <= i_cfg_data[7:0];
                dec_pkg::CFG_RING_SCALE:     r_cfg.ring_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_class};
    assign o_cfg_ready     = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/dec_root.sv
// Iterative ring unit: floor(sqrt(dividend / divisor)) on one shared subtractor.
`default_nettype none
module dec_root #(
    parameter int QW = 23,
    parameter int RW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [QW-1:0] i_dividend,
    input  wire logic [15:0]   i_divisor,
    output logic               o_done,
    output logic [RW-1:0]      o_root
);

    localparam int XW = 2 * RW;
    localparam int SW = (RW + 3 > 17) ? RW + 3 : 17;
    localparam int CW = $clog2(QW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [XW-1:0] r_x;
    logic [RW-1:0] r_root;
    logic [15:0]   r_div;
    logic          r_done;

    logic [SW-1:0] op_a;
    logic [SW-1:0] op_b;
    logic [SW:0]   diff;
    logic          ge;

    // Shared compare/subtract: quotient bit during divide, root bit during sqrt
    always_comb begin
        case (r_state)
            ST_SQRT: begin
                op_a = {r_rem[SW-3:0], r_x[XW-1:XW-2]};
                op_b = SW'({r_root, 2'b01});
            end
            default: begin
                op_a = {r_rem[SW-2:0], r_x[QW-1]};
                op_b = SW'(r_div);
            end
        endcase
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[SW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_DIV;
                        r_cnt   <= CW'(QW - 1);
                        r_rem   <= '0;
                        r_x     <= XW'(i_dividend);
                        // a zero scale divides as one
                        r_div   <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
                    end
                end
                ST_DIV: begin
                    r_x[QW-1:0] <= {r_x[QW-2:0], ge};
                    if (r_cnt == '0) begin
                        r_state <= ST_SQRT;
                        r_cnt   <= CW'(RW - 1);
                        r_rem   <= '0;
                        r_root  <= '0;
                    end else begin
                        r_rem <= ge ? diff[SW-1:0] : op_a;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= ge ? diff[SW-1:0] : op_a;
                    r_root <= {r_root[RW-2:0], ge};
                    r_x    <= {r_x[XW-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

FILE: rtl/dec_class.sv
// Edge rule evaluation for one pixel against the pixel below it.
`default_nettype none
module dec_class #(
    parameter int DIST_BITS = 24,
    parameter int RW        = 12
) (
    input  wire logic [DIST_BITS-1:0] i_d,
    input  wire logic [15:0]          i_h,
    input  wire logic [DIST_BITS-1:0] i_pd,
    input  wire logic [15:0]          i_ph,
    input  wire logic [RW-1:0]        i_ring,
    input  wire logic [RW-1:0]        i_pring,
    input  wire logic [DIST_BITS+7:0] i_lhs,
    input  wire logic [DIST_BITS+7:0] i_rhs,
    input  wire logic                 i_start,
    input  wire dec_pkg::t_cfg        i_cfg,
    output dec_pkg::t_cls_res         o_res
);

    logic wet;
    logic wet_prev;
    logic above;
    logic above_prev;
    logic sky;
    logic sky_prev;

    always_comb begin
        wet        = $signed(i_h)  < $signed(i_cfg.water_level);
        wet_prev   = $signed(i_ph) < $signed(i_cfg.water_level);
        above      = $signed(i_h)  > $signed(i_cfg.water_level);
        above_prev = $signed(i_ph) > $signed(i_cfg.water_level);
        sky        = i_d[DIST_BITS-1];
        sky_prev   = i_pd[DIST_BITS-1];

        o_res.edge_class = dec_pkg::CLS_NONE;
        o_res.freeze     = 1'b0;
        if (i_start) begin
            o_res.edge_class = dec_pkg::CLS_NONE;
        end else if (wet && wet_prev) begin
            o_res.edge_class = dec_pkg::CLS_NONE;
        end else if (i_lhs > i_rhs) begin
            o_res.edge_class = dec_pkg::CLS_MAJOR;
        end else if ((wet && above_prev) || (above && wet_prev)) begin
            o_res.edge_class = dec_pkg::CLS_MAJOR;
        end else if (sky) begin
            o_res.freeze = 1'b1;
        end else if (!sky_prev && (i_ring > i_pring)) begin
            o_res.edge_class = dec_pkg::CLS_MINOR;
        end
    end

endmodule
`default_nettype wire
